### rtl/tcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Request and result types, request mode codes and control characters for the
// text console with cursor and scroll.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // field widths of the request and result
  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  // request modes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  // control characters seen by put
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0d;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0a;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } rsp_t;

endpackage

### rtl/tcc_char_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_char_ram
// Single-port character store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module tcc_char_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             addr,
  input  logic [tcc_pkg::CHAR_W-1:0] wdata,
  output logic [tcc_pkg::CHAR_W-1:0] rdata
);

  logic [tcc_pkg::CHAR_W-1:0] mem [DEPTH];

  // write or read at one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/text_console_cursor_scroll_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top
// Teletype text console over a COLS x ROWS character store with a cursor.
// Scrolling moves a circular top-row pointer and clears the new bottom row.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------
//  request   | start, busy          | request  (tcc_pkg::req_t)
//  result    | done (one-cycle)     | result   (tcc_pkg::rsp_t)
//
//  Put of an ordinary byte without wrap, carriage return, write and read do
//  not hold busy: the result strobes in the next cycle and a new request may
//  be taken in that same cycle. Line feed and a put that wraps hold busy
//  while the new current row is zeroed, one cell per cycle through the
//  single memory port. Clear screen holds busy while every cell is zeroed.
//  After reset a clearing pass runs with busy high.
//  The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  tcc_pkg::req_t  request,
  output logic           done,
  output tcc_pkg::rsp_t  result
);

  localparam int CELLS  = COLS * ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int XW     = $clog2(COLS);
  localparam int YW     = $clog2(ROWS);
  localparam int COL_W  = tcc_pkg::COL_W;
  localparam int ROW_W  = tcc_pkg::ROW_W;
  localparam int CHAR_W = tcc_pkg::CHAR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROW_SETUP,
    S_SWEEP
  } state_t;

  state_t          state;
  logic [XW-1:0]   cx;
  logic [YW-1:0]   cy;
  logic [YW-1:0]   top;
  logic [YW-1:0]   sweep_row;
  logic [AW-1:0]   sweep_addr;
  logic [AW-1:0]   sweep_last;
  logic            report;
  logic            rd_flag;

  logic              accept;
  logic              in_inside;
  logic [YW-1:0]     in_row;
  logic [XW-1:0]     in_col;
  logic [AW-1:0]     in_addr;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     row_base;
  logic              nl_wrap;
  logic [YW-1:0]     nl_row;
  logic [YW-1:0]     top_inc;
  logic              col_last;
  logic              is_ctrl;

  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [CHAR_W-1:0] mem_rdata;

  // logical row to physical row through the top-row pointer
  function automatic logic [YW-1:0] phys_row(input logic [YW-1:0] y,
                                             input logic [YW-1:0] t);
    logic [YW:0] sum;
    sum = (YW+1)'(y) + (YW+1)'(t);
    if (int'(sum) >= ROWS) begin
      sum = sum - (YW+1)'(ROWS);
    end
    return sum[YW-1:0];
  endfunction

  // physical row and column to memory address
  function automatic logic [AW-1:0] cell_addr(input logic [YW-1:0] pr,
                                              input logic [XW-1:0] c);
    return AW'(AW'(pr) * AW'(COLS)) + AW'(c);
  endfunction

  // request decode and address generation
  always_comb begin
    accept    = start && (state == S_IDLE);
    in_inside = (int'(request.col) < COLS) && (int'(request.row) < ROWS);
    in_row    = YW'(request.row);
    in_col    = XW'(request.col);
    in_addr   = cell_addr(phys_row(in_row, top), in_col);
    cur_addr  = cell_addr(phys_row(cy, top), cx);
    row_base  = cell_addr(sweep_row, '0);
    nl_wrap   = (cy == YW'(ROWS - 1));
    top_inc   = (top == YW'(ROWS - 1)) ? '0 : top + YW'(1);
    nl_row    = nl_wrap ? top : phys_row(cy + YW'(1), top);
    col_last  = (cx == XW'(COLS - 1));
    is_ctrl   = (request.char_code == tcc_pkg::CHAR_CR) ||
                (request.char_code == tcc_pkg::CHAR_LF);
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = in_addr;
    mem_wdata = request.char_code;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.mode)
            tcc_pkg::MODE_PUT: begin
              mem_we   = !is_ctrl;
              mem_addr = cur_addr;
            end
            tcc_pkg::MODE_WRITE: mem_we = in_inside;
            default: mem_we = 1'b0;
          endcase
        end
      end
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_addr;
        mem_wdata = '0;
      end
      default: mem_we = 1'b0;
    endcase
  end

  tcc_char_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // sequencer, cursor and scroll pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      sweep_last <= AW'(CELLS - 1);
      sweep_row  <= '0;
      report     <= 1'b0;
      done       <= 1'b0;
      rd_flag    <= 1'b0;
      cx         <= '0;
      cy         <= '0;
      top        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_flag <= (request.mode == tcc_pkg::MODE_READ) && in_inside;
            case (request.mode)
              tcc_pkg::MODE_PUT: begin
                if (request.char_code == tcc_pkg::CHAR_CR) begin
                  cx   <= '0;
                  done <= 1'b1;
                end else if (request.char_code == tcc_pkg::CHAR_LF || col_last) begin
                  // new line: advance or scroll, then zero the new row
                  if (request.char_code != tcc_pkg::CHAR_LF) begin
                    cx <= '0;
                  end
                  if (nl_wrap) begin
                    top <= top_inc;
                  end else begin
                    cy <= cy + YW'(1);
                  end
                  sweep_row <= nl_row;
                  report    <= 1'b1;
                  done      <= 1'b0;
                  state     <= S_ROW_SETUP;
                end else begin
                  cx   <= cx + XW'(1);
                  done <= 1'b1;
                end
              end
              tcc_pkg::MODE_CLEAR: begin
                cx         <= '0;
                cy         <= '0;
                top        <= '0;
                sweep_addr <= '0;
                sweep_last <= AW'(CELLS - 1);
                report     <= 1'b1;
                done       <= 1'b0;
                state      <= S_SWEEP;
              end
              default: done <= 1'b1;
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_ROW_SETUP: begin
          sweep_addr <= row_base;
          sweep_last <= row_base + AW'(COLS - 1);
          done       <= 1'b0;
          state      <= S_SWEEP;
        end
        S_SWEEP: begin
          if (sweep_addr == sweep_last) begin
            state <= S_IDLE;
            done  <= report;
          end else begin
            sweep_addr <= sweep_addr + AW'(1);
            done       <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  // handshake and result
  always_comb begin
    busy              = (state != S_IDLE);
    result.read_char  = rd_flag ? mem_rdata : '0;
    result.cursor_col = COL_W'(cx);
    result.cursor_row = ROW_W'(cy);
  end

  // a result only shows while the block is free
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // an accepted request either finishes at once or starts a sweep
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted request neither finished nor busy");

  // cursor row and top-row pointer stay on the screen
  a_rows_range: assert property (@(posedge clk) disable iff (rst)
    (int'(cy) < ROWS) && (int'(top) < ROWS))
    else $error("row pointer out of range");

  // a read result only follows a read-mode request
  a_read_flag: assert property (@(posedge clk) disable iff (rst)
    $rose(rd_flag) |-> (done && $past(request.mode) == tcc_pkg::MODE_READ))
    else $error("read data flagged without read request");

endmodule
